[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZHC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("lzhc assertion failed");

// Next-cycle implication, disabled during reset.
`define LZHC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("lzhc assertion failed");

`endif

[design/lzhc_pkg.sv]
// Package for the hash-chain tokenizer: item types, memory entry type,
// sequencer states, sizes and the position hash. No dependencies.
`default_nettype none
package lzhc_pkg;
   localparam int HIST_AW     = 16;
   localparam int HASH_AW     = 16;
   localparam int POS_W       = 32;
   localparam int MAX_MATCH   = 32;
   localparam int WINDOW_SPAN = 32768;
   localparam int CHAIN_CAP   = 64;
   localparam logic [6:0] CHAIN_RESET = 7'd64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic        is_match;
      logic [7:0]  literal_byte;
      logic [14:0] distance_minus_one;
      logic [5:0]  match_length;
      logic        last_token;
   } rsp_item_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
   } link_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_INS, ST_H0, ST_H1, ST_H2, ST_H3,
      ST_CAND, ST_CMP, ST_LINK, ST_TOKEN
   } state_type;

   function automatic logic [HASH_AW-1:0] hash3(input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2);
      logic [23:0] h;
      h = {b0, b1, b2};
      h = h ^ (h >> 12);
      return h[HASH_AW-1:0];
   endfunction
endpackage
`default_nettype wire

[design/lz77_hash_chain_tokenizer.sv]
// Top level of the greedy hash-chain LZ77 tokenizer: sequencer, byte
// compare unit and registers. Uses lzhc_pkg, lzhc_ram, assert_macros.svh.
//
// Usage: bytes enter on req_ (data_byte, end_of_stream); tokens leave on
// rsp_ as literal or match items. csr_ writes max_chain_steps (reset 64,
// values above 64 act as 64); write it only while idle.
// A token is decided once 32 bytes of lookahead are held, so normally
// at most one token follows each byte; end_of_stream flushes all pending
// tokens and marks the final one with last_token.
// With no token due, a byte goes from idle through the check back to idle. A token
// costs an insert for each position it covers, a hash of the search position,
// and per chain candidate a setup step, a compare step per byte compared and a
// link step, up to 64 candidates; the history RAM is duplicated so its two read
// ports feed the only byte compare unit. req_ready is high only between items.
// Reset, and every end of stream, starts a pass clearing all 65536 entries of
// the head table; no item is accepted meanwhile. A stalled receiver holds the
// token register and the sequencer waits before loading the next token.
`default_nettype none
module lz77_hash_chain_tokenizer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lzhc_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output lzhc_pkg::rsp_item_type     rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [6:0]            csr_data
);
   import lzhc_pkg::*;
`include "assert_macros.svh"

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   sp_ff, sp_in, t_ff, t_in, ip_ff, ip_in, hp_ff, hp_in;
   logic [POS_W-1:0]   j_ff, j_in;
   logic               eos_ff, eos_in, srch_ff, srch_in, have_ff, have_in;
   logic [7:0]         b0_ff, b0_in, b1_ff, b1_in;
   logic [HASH_AW-1:0] hidx_ff, hidx_in, cnt_ff, cnt_in;
   logic [6:0]         steps_ff, steps_in, max_ff, max_in;
   logic [5:0]         k_ff, k_in, maxlen_ff, maxlen_in, best_len_ff, best_len_in;
   logic [15:0]        best_dist_ff, best_dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               hist_we;
   logic [HIST_AW-1:0] hist_ra, hist_rb;
   logic [7:0]         hist_qa, hist_qb;
   logic               head_we, link_we;
   logic [HASH_AW-1:0] head_waddr, head_raddr;
   link_type           head_wdata, head_q, link_q;

   logic [POS_W-1:0]   avail, cand_dist, ins_gap, t_next;
   logic [6:0]         cap;
   logic [5:0]         kn, len;
   logic               chk_done, byte_eq, is_match, rsp_free;
   logic [HASH_AW-1:0] hash_now;

   assign avail     = sp_ff - t_ff;
   assign cand_dist = t_ff - j_ff;
   assign ins_gap   = sp_ff - ip_ff;
   assign cap       = (max_ff > 7'(CHAIN_CAP)) ? 7'(CHAIN_CAP) : max_ff;
   assign kn        = k_ff + 6'd1;
   assign byte_eq   = hist_qa == hist_qb;
   assign len       = byte_eq ? kn : k_ff;
   assign chk_done  = (avail == '0) || (!eos_ff && avail < POS_W'(MAX_MATCH));
   assign hash_now  = hash3(b0_ff, b1_ff, hist_qa);
   assign is_match  = best_len_ff >= 6'd3;
   assign t_next    = t_ff + (is_match ? {{(POS_W-6){1'b0}}, best_len_ff} : POS_W'(1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   lzhc_ram #(.ADDR_W(HIST_AW), .DATA_W(8)) u_hist_a (
      .clock(clock), .we(hist_we), .waddr(sp_ff[HIST_AW-1:0]),
      .wdata(req_item.data_byte), .raddr(hist_ra), .rdata(hist_qa));
   lzhc_ram #(.ADDR_W(HIST_AW), .DATA_W(8)) u_hist_b (
      .clock(clock), .we(hist_we), .waddr(sp_ff[HIST_AW-1:0]),
      .wdata(req_item.data_byte), .raddr(hist_rb), .rdata(hist_qb));
   lzhc_ram #(.ADDR_W(HASH_AW), .DATA_W($bits(link_type))) u_heads (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_q));
   lzhc_ram #(.ADDR_W(HIST_AW), .DATA_W($bits(link_type))) u_links (
      .clock(clock), .we(link_we), .waddr(ip_ff[HIST_AW-1:0]), .wdata(head_q),
      .raddr(j_ff[HIST_AW-1:0]), .rdata(link_q));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (cnt_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (chk_done) state_in = eos_ff ? ST_CLEAR : ST_IDLE;
            else state_in = ST_INS;
         end
         ST_INS: begin
            if (ip_ff != t_ff && ins_gap < POS_W'(3)) state_in = ST_INS;
            else state_in = ST_H0;
         end
         ST_H0: state_in = ST_H1;
         ST_H1: state_in = ST_H2;
         ST_H2: state_in = ST_H3;
         ST_H3: begin
            if (!srch_ff) state_in = ST_INS;
            else if (maxlen_ff < 6'd3) state_in = ST_TOKEN;
            else state_in = ST_CAND;
         end
         ST_CAND: begin
            if (!have_ff || steps_ff >= cap || cand_dist == '0 ||
                cand_dist > POS_W'(WINDOW_SPAN)) state_in = ST_TOKEN;
            else state_in = ST_CMP;
         end
         ST_CMP:   state_in = (byte_eq && kn < maxlen_ff) ? ST_CMP : ST_LINK;
         ST_LINK:  state_in = ST_CAND;
         ST_TOKEN: if (rsp_free) state_in = ST_CHECK;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      sp_in = sp_ff; t_in = t_ff; ip_in = ip_ff; hp_in = hp_ff; j_in = j_ff;
      eos_in = eos_ff; srch_in = srch_ff; have_in = have_ff;
      b0_in = b0_ff; b1_in = b1_ff; hidx_in = hidx_ff; cnt_in = cnt_ff;
      steps_in = steps_ff; k_in = k_ff; maxlen_in = maxlen_ff;
      best_len_in = best_len_ff; best_dist_in = best_dist_ff;
      max_in = csr_valid ? csr_data : max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in = rsp_item_ff;
      hist_we = 1'b0; head_we = 1'b0; link_we = 1'b0;
      hist_ra = hp_ff[HIST_AW-1:0]; hist_rb = t_ff[HIST_AW-1:0];
      head_raddr = hidx_ff; head_waddr = hidx_ff;
      head_wdata = '{valid: 1'b1, pos: ip_ff};
      case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1; head_waddr = cnt_ff; head_wdata = '0;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               hist_we = 1'b1;
               sp_in = sp_ff + 1'b1;
               eos_in = req_item.end_of_stream;
            end
         end
         ST_CHECK: begin
            if (chk_done && eos_ff) begin
               sp_in = '0; t_in = '0; ip_in = '0; cnt_in = '0;
            end
         end
         ST_INS: begin
            if (ip_ff != t_ff) begin
               if (ins_gap < POS_W'(3)) ip_in = ip_ff + 1'b1;
               else begin
                  hp_in = ip_ff; srch_in = 1'b0;
               end
            end else begin
               hp_in = t_ff; srch_in = 1'b1;
               maxlen_in = (avail < POS_W'(MAX_MATCH)) ? avail[5:0] : 6'(MAX_MATCH);
               best_len_in = '0; best_dist_in = '0;
            end
         end
         ST_H0: begin
            hist_ra = hp_ff[HIST_AW-1:0];
            hist_rb = hp_ff[HIST_AW-1:0] + 1'b1;
         end
         ST_H1: begin
            b0_in = hist_qa; b1_in = hist_qb;
            hist_ra = hp_ff[HIST_AW-1:0] + 2'd2;
         end
         ST_H2: begin
            head_raddr = hash_now; hidx_in = hash_now;
         end
         ST_H3: begin
            if (!srch_ff) begin
               link_we = 1'b1; head_we = 1'b1;
               ip_in = ip_ff + 1'b1;
            end else begin
               have_in = head_q.valid; j_in = head_q.pos; steps_in = '0;
            end
         end
         ST_CAND: begin
            hist_ra = j_ff[HIST_AW-1:0]; hist_rb = t_ff[HIST_AW-1:0]; k_in = '0;
         end
         ST_CMP: begin
            hist_ra = j_ff[HIST_AW-1:0] + HIST_AW'(kn);
            hist_rb = t_ff[HIST_AW-1:0] + HIST_AW'(kn);
            if (byte_eq && kn < maxlen_ff) k_in = kn;
            else if (len > best_len_ff) begin
               best_len_in = len; best_dist_in = cand_dist[15:0];
            end
         end
         ST_LINK: begin
            have_in = link_q.valid; j_in = link_q.pos; steps_in = steps_ff + 1'b1;
         end
         ST_TOKEN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in.is_match = is_match;
               rsp_item_in.literal_byte = is_match ? 8'd0 : b0_ff;
               rsp_item_in.distance_minus_one =
                  is_match ? 15'(best_dist_ff - 16'd1) : 15'd0;
               rsp_item_in.match_length = is_match ? best_len_ff : 6'd0;
               rsp_item_in.last_token = eos_ff && (t_next == sp_ff);
               t_in = t_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sp_ff <= '0; t_ff <= '0; ip_ff <= '0; cnt_ff <= '0;
         eos_ff <= 1'b0; max_ff <= CHAIN_RESET; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in; t_ff <= t_in; ip_ff <= ip_in; cnt_ff <= cnt_in;
         eos_ff <= eos_in; max_ff <= max_in; rsp_valid_ff <= rsp_valid_in;
      end
      hp_ff <= hp_in; j_ff <= j_in; srch_ff <= srch_in; have_ff <= have_in;
      b0_ff <= b0_in; b1_ff <= b1_in; hidx_ff <= hidx_in;
      steps_ff <= steps_in; k_ff <= k_in; maxlen_ff <= maxlen_in;
      best_len_ff <= best_len_in; best_dist_ff <= best_dist_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `LZHC_ASSERT_IMP(a_search_after_inserts, state_ff == ST_H0 && srch_ff, ip_ff == t_ff)
   `LZHC_ASSERT_IMP(a_match_len, rsp_valid_ff && rsp_item_ff.is_match,
      rsp_item_ff.match_length >= 6'd3 && rsp_item_ff.match_length <= 6'(MAX_MATCH))
   `LZHC_ASSERT_IMP(a_steps_cap, state_ff == ST_CAND, steps_ff <= 7'(CHAIN_CAP))
   `LZHC_ASSERT_NXT(a_token_load, state_ff == ST_TOKEN && rsp_free, rsp_valid_ff)
endmodule
`default_nettype wire

[design/lzhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzhc_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem_ff [(1 << ADDR_W)];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for lz77_hash_chain_tokenizer: byte streams in, literal/match tokens out,
// each checked against a hash-chain match predictor. Depends on lzhc_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import lzhc_pkg::*;

   localparam int HIST_SIZE = 1 << 16;
   localparam int WIN = 32768;
   localparam int STEP_CAP = 64;
   localparam int LOOKAHEAD = 32;
   localparam int RAND_ITEMS = 480;
   localparam int TAIL_LEN = 60;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type tok;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_data = '0;

   lz77_hash_chain_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   bit [7:0]  hist [HIST_SIZE];
   bit        head_ok [HIST_SIZE];
   bit [31:0] head_at [HIST_SIZE];
   bit        link_ok [HIST_SIZE];
   bit [31:0] link_at [HIST_SIZE];
   bit [31:0] byte_count, tok_start, hashed_upto;
   bit [6:0]  chain_limit = CHAIN_RESET;

   rsp_item_type expected_tokens[$];
   int  mismatches = 0, tokens_seen = 0, bytes_sent = 0, streams_done = 0;
   bit  quiet = 1'b0;

   function automatic bit [15:0] pos_hash(input bit [31:0] p);
      bit [23:0] h;
      h = {hist[p[15:0]], hist[16'(p + 1)], hist[16'(p + 2)]};
      h = h ^ (h >> 12);
      return h[15:0];
   endfunction

   task automatic chain_insert(input bit [31:0] p);
      bit [15:0] h;
      if (byte_count - p < 3) return;
      h = pos_hash(p);
      link_ok[p[15:0]] = head_ok[h];
      link_at[p[15:0]] = head_at[h];
      head_ok[h] = 1'b1;
      head_at[h] = p;
   endtask

   task automatic tokenize_byte(input req_item_type it);
      bit [31:0] t, avail, maxlen, best_len, best_dist, j, cand_dist, k, steps, cap;
      bit [15:0] h;
      bit        have;
      int        count;
      rsp_item_type tok;
      t = tok_start;
      cap = (chain_limit > STEP_CAP) ? STEP_CAP : chain_limit;
      hist[byte_count[15:0]] = it.data_byte;
      byte_count++;
      count = 0;
      while (count < LOOKAHEAD) begin
         avail = byte_count - t;
         if (avail == 0) break;
         if (!it.end_of_stream && avail < LOOKAHEAD) break;
         while (hashed_upto != t) begin
            chain_insert(hashed_upto);
            hashed_upto++;
         end
         maxlen = (avail < LOOKAHEAD) ? avail : LOOKAHEAD;
         best_len = 0;
         best_dist = 0;
         if (maxlen >= 3) begin
            h = pos_hash(t);
            have = head_ok[h];
            j = head_at[h];
            steps = 0;
            while (have && steps < cap) begin
               cand_dist = t - j;
               if (cand_dist == 0 || cand_dist > WIN) break;
               k = 0;
               while (k < maxlen && hist[16'(j + k)] == hist[16'(t + k)]) k++;
               if (k > best_len) begin
                  best_len = k;
                  best_dist = cand_dist;
               end
               have = link_ok[j[15:0]];
               j = link_at[j[15:0]];
               steps++;
            end
         end
         tok = '0;
         if (best_len >= 3) begin
            tok.is_match = 1'b1;
            tok.distance_minus_one = 15'(best_dist - 1);
            tok.match_length = 6'(best_len);
            t += best_len;
         end else begin
            tok.literal_byte = hist[t[15:0]];
            t += 1;
         end
         expected_tokens.push_back(tok);
         count++;
      end
      tok_start = t;
      if (it.end_of_stream) begin
         if (count > 0) expected_tokens[expected_tokens.size() - 1].last_token = 1'b1;
         foreach (head_ok[i]) head_ok[i] = 1'b0;
         byte_count = 0;
         tok_start = 0;
         hashed_upto = 0;
         streams_done++;
      end
   endtask

   // token checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", rsp_item);
         end else begin
            if (rsp_item !== expected_tokens[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token mismatch: expected %p got %p", expected_tokens[0], rsp_item);
            end
            void'(expected_tokens.pop_front());
         end
      end
   end

   // receiver stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= !reset;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input req_item_type it, input bit typed, input rsp_item_type tok);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tokenize_byte(it);
      if (typed) begin
         void'(expected_tokens.pop_back());
         expected_tokens.push_back(tok);
      end
      bytes_sent++;
   endtask

   task automatic write_chain_limit(input bit [6:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      chain_limit = v;
      csr_valid <= 1'b0;
   endtask

   dir_row_type dir_rows[24];
   rsp_item_type no_tok = '0;

   initial begin
      req_item_type it;
      bit [7:0] pat [40];
      bit [7:0] alpha [4];
      int len, mode, pos;
      bit [6:0] limits[$] = '{7'd1, 7'd0, 7'd127, 7'd64};
      dir_rows[0] = '{'{8'hff, 1'b1}, 1'b1, '{1'b0, 8'hff, 15'd0, 6'd0, 1'b1}};
      dir_rows[1] = '{'{8'h00, 1'b1}, 1'b1, '{1'b0, 8'h00, 15'd0, 6'd0, 1'b1}};
      dir_rows[2] = '{'{8'h61, 1'b0}, 1'b0, '0};
      dir_rows[3] = '{'{8'h62, 1'b1}, 1'b0, '0};
      for (int i = 4; i < 24; i++)
         dir_rows[i] = '{'{(i % 3 == 0) ? 8'hff : (i % 3 == 1) ? 8'h00 : 8'h5a,
                           1'(i == 23)}, 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_chain_limit(CHAIN_RESET);
      foreach (dir_rows[i]) send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].tok);

      while (bytes_sent < RAND_ITEMS - 120) begin
         write_chain_limit(limits.size() ? limits.pop_front() : 7'($urandom_range(0, 127)));
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(40, 130);
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
         for (int i = 0; i < len; i++) begin
            case (mode)
               0: it.data_byte = alpha[$urandom_range(0, 3)];
               1: it.data_byte = 8'($urandom);
               default: it.data_byte = (i % 7 < 5) ? alpha[i % 3] : alpha[3];
            endcase
            it.end_of_stream = (i == len - 1);
            send_byte(it, 1'b0, no_tok);
         end
      end

      // closing stream without idling, holding one repeated run
      write_chain_limit(7'd64);
      quiet = 1'b1;
      for (int i = 0; i < 40; i++) pat[i] = 8'($urandom);
      for (pos = 0; pos < TAIL_LEN; pos++) begin
         if (pos < 20) it.data_byte = pat[pos];
         else if (pos >= 25 && pos < 45) it.data_byte = pat[pos - 25];
         else it.data_byte = 8'($urandom);
         it.end_of_stream = (pos == TAIL_LEN - 1);
         send_byte(it, 1'b0, no_tok);
      end
      req_valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      $display("%0d bytes in %0d streams, %0d tokens checked, %0d mismatches",
               bytes_sent, streams_done, tokens_seen, mismatches);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("timeout with %0d tokens outstanding", expected_tokens.size());
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+design
design/lzhc_pkg.sv
design/lzhc_ram.sv
design/lz77_hash_chain_tokenizer.sv
dv/tb.sv
